### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, suspended while arst_n is low.
`define SCD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Concurrent check on clk that also runs while reset is applied.
`define SCD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/scd_pkg.sv
package scd_pkg;

	// Buffer and LFO table sizes, both powers of two.
	localparam int BUF_AW    = 12;
	localparam int BUF_DEPTH = 1 << BUF_AW;
	localparam int LFO_AW    = 18;
	localparam int LFO_DEPTH = 1 << LFO_AW;

	// The power-up sweep covers the larger of the two memories.
	localparam int CLR_AW    = (LFO_AW > BUF_AW) ? LFO_AW : BUF_AW;

	// Field widths.
	localparam int PERIOD_W   = 19;
	localparam int PHASE_W    = 18;
	localparam int INDEX_W    = 18;
	localparam int TVAL_W     = 12;
	localparam int SAMPLE_W   = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 19;

	// Width that holds both the period and the table depth itself.
	localparam int EP_W = (PERIOD_W > LFO_AW + 1) ? PERIOD_W : LFO_AW + 1;

	// Queue depths, powers of two.
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

	typedef enum logic {
		ACT_LOAD   = 1'b0,
		ACT_SAMPLE = 1'b1
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LFO_PERIOD  = 2'd0,
		REG_RIGHT_PHASE = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		action_t                     action;
		logic [INDEX_W-1:0]          table_index;
		logic [TVAL_W-1:0]           table_value;
		logic signed [SAMPLE_W-1:0]  in_left;
		logic signed [SAMPLE_W-1:0]  in_right;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0]  out_left;
		logic signed [SAMPLE_W-1:0]  out_right;
	} result_t;

	// One sample on its way from the front to the back.
	typedef struct packed {
		logic [BUF_AW-1:0]           wp;
		logic [BUF_AW-1:0]           dly_left;
		logic [BUF_AW-1:0]           dly_right;
		logic                        bypass;
		logic signed [SAMPLE_W-1:0]  in_left;
		logic signed [SAMPLE_W-1:0]  in_right;
	} cmd_t;

	typedef struct packed {
		logic                        busy;
		logic [CLR_AW-1:0]           addr;
	} clr_t;

	typedef struct packed {
		logic                        head_valid;
		logic [CMDQ_AW:0]            count;
	} cmdq_stat_t;

endpackage

### rtl/scd_ram.sv
module scd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and two registered read ports; a read of the address
	// being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end

endmodule

### rtl/scd_cmd_queue.sv
module scd_cmd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  scd_pkg::cmd_t       din,
	input  logic                pop,
	output scd_pkg::cmd_t       head,
	output scd_pkg::cmdq_stat_t stat
);

	scd_pkg::cmd_t                entries_q [scd_pkg::CMDQ_DEPTH];
	logic [scd_pkg::CMDQ_AW-1:0]  wr_ptr_q;
	logic [scd_pkg::CMDQ_AW-1:0]  rd_ptr_q;
	logic [scd_pkg::CMDQ_AW:0]    count_q;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (scd_pkg::CMDQ_AW + 1)'(push)
				- (scd_pkg::CMDQ_AW + 1)'(pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= din;
		end
	end

	assign head            = entries_q[rd_ptr_q];
	assign stat.head_valid = (count_q != '0);
	assign stat.count      = count_q;

endmodule

### rtl/scd_front.sv
module scd_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  scd_pkg::item_t                    item,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [scd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [scd_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  scd_pkg::cmdq_stat_t               q_stat,
	output logic                              cmd_push,
	output scd_pkg::cmd_t                     cmd,
	output scd_pkg::clr_t                     clr
);

	localparam int QL_W = scd_pkg::CMDQ_AW + 2;
	localparam int EP_W = scd_pkg::EP_W;

	// Next LFO position: step by one, back to zero at the period.
	function automatic logic [scd_pkg::PHASE_W-1:0] lfo_advance(
		input logic [scd_pkg::PHASE_W-1:0] pos,
		input logic [EP_W-1:0]             per
	);
		logic [scd_pkg::PHASE_W:0] n;
		n = {1'b0, pos} + 1'b1;
		return (EP_W'(n) >= per) ? '0 : n[scd_pkg::PHASE_W-1:0];
	endfunction

	logic                                 busy_q;
	logic [scd_pkg::CLR_AW-1:0]           clr_addr_q;
	logic [scd_pkg::PERIOD_W-1:0]         period_q;
	logic [scd_pkg::PHASE_W-1:0]          phase_q;
	logic [scd_pkg::PHASE_W-1:0]          left_pos_q;
	logic [scd_pkg::PHASE_W-1:0]          right_pos_q;
	logic [scd_pkg::BUF_AW-1:0]           wp_q;

	logic                                 valid_s1;
	logic [scd_pkg::BUF_AW-1:0]           wp_s1;
	logic                                 bypass_s1;
	logic signed [scd_pkg::SAMPLE_W-1:0]  in_left_s1;
	logic signed [scd_pkg::SAMPLE_W-1:0]  in_right_s1;

	logic [QL_W-1:0]                      q_load;
	logic                                 accept;
	logic                                 acc_sample;
	logic                                 acc_load;
	logic                                 index_ok;
	logic [EP_W-1:0]                      period_ext;
	logic [EP_W-1:0]                      eff_period;
	logic [scd_pkg::PHASE_W-1:0]          left_nxt;
	logic [scd_pkg::PHASE_W-1:0]          right_nxt;
	logic [scd_pkg::BUF_AW-1:0]           wp_nxt;
	logic                                 cfg_wr;
	logic [scd_pkg::PHASE_W-1:0]          new_phase;

	logic                                 tbl_we;
	logic [scd_pkg::LFO_AW-1:0]           tbl_waddr;
	logic [scd_pkg::TVAL_W-1:0]           tbl_wdata;
	logic [scd_pkg::LFO_AW-1:0]           tbl_ra0;
	logic [scd_pkg::LFO_AW-1:0]           tbl_ra1;
	logic [scd_pkg::TVAL_W-1:0]           tbl_rd0;
	logic [scd_pkg::TVAL_W-1:0]           tbl_rd1;

	// Power-up sweep over the delay table and the delay line.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign clr.busy = busy_q;
	assign clr.addr = clr_addr_q;

	// Input side: hold off while sweeping or when the command queue could
	// not take the sample that is still reading the table.
	assign q_load     = QL_W'(q_stat.count) + QL_W'(valid_s1);
	assign full       = busy_q || (q_load >= QL_W'(scd_pkg::CMDQ_DEPTH));
	assign accept     = push && !full;
	assign acc_sample = accept && (item.action == scd_pkg::ACT_SAMPLE);
	assign acc_load   = accept && (item.action == scd_pkg::ACT_LOAD);
	assign index_ok   = (EP_W'(item.table_index) < EP_W'(scd_pkg::LFO_DEPTH));

	// Effective period is clamped to the table depth.
	assign period_ext = EP_W'(period_q);
	assign eff_period = (period_ext > EP_W'(scd_pkg::LFO_DEPTH)) ?
		EP_W'(scd_pkg::LFO_DEPTH) : period_ext;

	assign left_nxt  = lfo_advance(left_pos_q, eff_period);
	assign right_nxt = lfo_advance(right_pos_q, eff_period);
	assign wp_nxt    = wp_q + 1'b1;

	// Configuration registers, always ready.
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && ((cfg_index == scd_pkg::REG_LFO_PERIOD)
		|| (cfg_index == scd_pkg::REG_RIGHT_PHASE));
	assign new_phase = (cfg_index == scd_pkg::REG_RIGHT_PHASE) ?
		cfg_data[scd_pkg::PHASE_W-1:0] : phase_q;

	// Register file and position counters; a register write restarts the LFOs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= '0;
			phase_q     <= '0;
			left_pos_q  <= '0;
			right_pos_q <= '0;
			wp_q        <= '0;
		end else if (cfg_wr) begin
			if (cfg_index == scd_pkg::REG_LFO_PERIOD) begin
				period_q <= cfg_data[scd_pkg::PERIOD_W-1:0];
			end else begin
				phase_q <= cfg_data[scd_pkg::PHASE_W-1:0];
			end
			left_pos_q  <= '0;
			right_pos_q <= new_phase;
		end else if (acc_sample) begin
			left_pos_q  <= left_nxt;
			right_pos_q <= right_nxt;
			wp_q        <= wp_nxt;
		end
	end

	// Delay table: sweep writes, load beats write, each sample reads both taps.
	assign tbl_we    = busy_q || (acc_load && index_ok);
	assign tbl_waddr = busy_q ? scd_pkg::LFO_AW'(clr_addr_q) :
		scd_pkg::LFO_AW'(item.table_index);
	assign tbl_wdata = busy_q ? '0 : item.table_value;
	assign tbl_ra0   = scd_pkg::LFO_AW'(left_nxt);
	assign tbl_ra1   = scd_pkg::LFO_AW'(right_nxt);

	scd_ram #(
		.WIDTH (scd_pkg::TVAL_W),
		.DEPTH (scd_pkg::LFO_DEPTH)
	) u_table (
		.clk    (clk),
		.we     (tbl_we),
		.waddr  (tbl_waddr),
		.wdata  (tbl_wdata),
		.raddr0 (tbl_ra0),
		.raddr1 (tbl_ra1),
		.rdata0 (tbl_rd0),
		.rdata1 (tbl_rd1)
	);

	// Stage 1 waits for the table data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc_sample;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_sample) begin
			wp_s1       <= wp_nxt;
			bypass_s1   <= (period_q == '0);
			in_left_s1  <= item.in_left;
			in_right_s1 <= item.in_right;
		end
	end

	// Delays are taken modulo the buffer depth.
	assign cmd_push      = valid_s1;
	assign cmd.wp        = wp_s1;
	assign cmd.dly_left  = scd_pkg::BUF_AW'(tbl_rd0);
	assign cmd.dly_right = scd_pkg::BUF_AW'(tbl_rd1);
	assign cmd.bypass    = bypass_s1;
	assign cmd.in_left   = in_left_s1;
	assign cmd.in_right  = in_right_s1;

endmodule

### rtl/scd_back.sv
module scd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  scd_pkg::cmdq_stat_t q_stat,
	input  scd_pkg::cmd_t       head,
	output logic                cmd_pop,
	input  scd_pkg::clr_t       clr,
	input  logic                pop,
	output logic                empty,
	output scd_pkg::result_t    result
);

	localparam int OL_W = scd_pkg::OUTQ_AW + 2;

	logic                                 valid_s2;
	logic                                 bypass_s2;
	logic                                 zero_left_s2;
	logic                                 zero_right_s2;
	logic signed [scd_pkg::SAMPLE_W-1:0]  in_left_s2;
	logic signed [scd_pkg::SAMPLE_W-1:0]  in_right_s2;

	scd_pkg::result_t                     outq_q [scd_pkg::OUTQ_DEPTH];
	logic [scd_pkg::OUTQ_AW-1:0]          out_wr_q;
	logic [scd_pkg::OUTQ_AW-1:0]          out_rd_q;
	logic [scd_pkg::OUTQ_AW:0]            out_count_q;

	logic [OL_W-1:0]                      out_load;
	logic                                 res_pop;
	logic                                 line_we;
	logic [scd_pkg::BUF_AW-1:0]           line_waddr;
	logic [scd_pkg::SAMPLE_W-1:0]         line_wdata;
	logic [scd_pkg::BUF_AW-1:0]           line_ra0;
	logic [scd_pkg::BUF_AW-1:0]           line_ra1;
	logic [scd_pkg::SAMPLE_W-1:0]         line_rd0;
	logic [scd_pkg::SAMPLE_W-1:0]         line_rd1;
	scd_pkg::result_t                     res_s2;

	// Take a command only when the result queue is sure to have room.
	assign out_load = OL_W'(out_count_q) + OL_W'(valid_s2);
	assign cmd_pop  = q_stat.head_valid && !clr.busy
		&& (out_load < OL_W'(scd_pkg::OUTQ_DEPTH));

	// Delay line: write the new right sample, read both taps behind it.
	assign line_we    = clr.busy || cmd_pop;
	assign line_waddr = clr.busy ? scd_pkg::BUF_AW'(clr.addr) : head.wp;
	assign line_wdata = clr.busy ? '0 : head.in_right;
	assign line_ra0   = head.wp - head.dly_left;
	assign line_ra1   = head.wp - head.dly_right;

	scd_ram #(
		.WIDTH (scd_pkg::SAMPLE_W),
		.DEPTH (scd_pkg::BUF_DEPTH)
	) u_line (
		.clk    (clk),
		.we     (line_we),
		.waddr  (line_waddr),
		.wdata  (line_wdata),
		.raddr0 (line_ra0),
		.raddr1 (line_ra1),
		.rdata0 (line_rd0),
		.rdata1 (line_rd1)
	);

	// Stage 2 waits for the line data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= cmd_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			bypass_s2     <= head.bypass;
			zero_left_s2  <= (head.dly_left == '0);
			zero_right_s2 <= (head.dly_right == '0);
			in_left_s2    <= head.in_left;
			in_right_s2   <= head.in_right;
		end
	end

	// A zero delay reads the cell written in the same cycle, so forward the
	// input; with the LFO stopped the left side passes its input through.
	always_comb begin
		if (bypass_s2) begin
			res_s2.out_left = in_left_s2;
		end else if (zero_left_s2) begin
			res_s2.out_left = in_right_s2;
		end else begin
			res_s2.out_left = $signed(line_rd0);
		end
		res_s2.out_right = zero_right_s2 ? in_right_s2 : $signed(line_rd1);
	end

	// Result queue.
	assign res_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q    <= '0;
			out_rd_q    <= '0;
			out_count_q <= '0;
		end else begin
			if (valid_s2) begin
				out_wr_q <= out_wr_q + 1'b1;
			end
			if (res_pop) begin
				out_rd_q <= out_rd_q + 1'b1;
			end
			out_count_q <= out_count_q + (scd_pkg::OUTQ_AW + 1)'(valid_s2)
				- (scd_pkg::OUTQ_AW + 1)'(res_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			outq_q[out_wr_q] <= res_s2;
		end
	end

	assign empty  = (out_count_q == '0);
	assign result = outq_q[out_rd_q];

endmodule

### rtl/stereo_chorus_delay_line_top.sv
// Path: a sample beat goes through the table read and stage 1, the command queue,
// the delay line read and stage 2, then the result queue, where it can be popped.
// Throughput: one beat per cycle while full is low; load beats return no result.
// The table and delay line each have two registered read ports, which sets the
// pipeline depth. Reset: control state clears at once, then a sweep zeroes the
// table and delay line with full held high; configuration writes are taken throughout.
module stereo_chorus_delay_line_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  scd_pkg::item_t                    item,
	output logic                              empty,
	input  logic                              pop,
	output scd_pkg::result_t                  result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [scd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [scd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	scd_pkg::cmdq_stat_t q_stat;
	scd_pkg::cmd_t       cmd_in;
	scd_pkg::cmd_t       cmd_head;
	scd_pkg::clr_t       clr;
	logic                cmd_push;
	logic                cmd_pop;

	// Front: handshake, registers, LFO positions and delay table.
	scd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_stat    (q_stat),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.clr       (clr)
	);

	// Decoupling queue between the two halves.
	scd_cmd_queue u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.pop    (cmd_pop),
		.head   (cmd_head),
		.stat   (q_stat)
	);

	// Back: delay line and result queue.
	scd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_stat  (q_stat),
		.head    (cmd_head),
		.cmd_pop (cmd_pop),
		.clr     (clr),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

### rtl/scd_checker.sv
`include "assert_macros.svh"

module scd_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic                              full,
	input  scd_pkg::item_t                    item,
	input  logic                              empty,
	input  logic                              pop,
	input  scd_pkg::result_t                  result,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [scd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [scd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int MaxOut = scd_pkg::CMDQ_DEPTH + scd_pkg::OUTQ_DEPTH;
	localparam int OCNT_W = $clog2(MaxOut + 2);

	logic              acc_sample;
	logic              res_pop;
	logic [OCNT_W-1:0] outstanding_q;

	assign acc_sample = push && !full && (item.action == scd_pkg::ACT_SAMPLE);
	assign res_pop    = pop && !empty;

	// Sample beats taken in but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= outstanding_q + OCNT_W'(acc_sample) - OCNT_W'(res_pop);
		end
	end

	`SCD_ASSERT(a_result_held, (!empty && !pop) |=> (!empty && $stable(result)), "waiting result changed")
	`SCD_ASSERT(a_pop_has_sample, res_pop |-> (outstanding_q != '0), "result without a sample")
	`SCD_ASSERT(a_no_phantom, ((outstanding_q == '0) && !acc_sample) |=> empty, "result appeared from nothing")
	`SCD_ASSERT(a_bounded, outstanding_q <= OCNT_W'(MaxOut), "more samples in flight than storage")

endmodule

bind stereo_chorus_delay_line_top scd_checker u_scd_checker (.*);
